/* rtl/sorted_table_binary_search_defines.svh */
// Assertion macros used by the checker file of the sorted table search block.
// No dependencies; pulled in by `include.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define STBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define STBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/stbs_pkg.sv */
// Shared types and constants for the sorted table search block.
// No dependencies.
package stbs_pkg;

  localparam int TABLE_SIZE_DEF = 16;
  localparam int KEY_CHARS_DEF  = 8;
  localparam int KEY_W          = 64;
  localparam int POS_W          = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_RDA,
    ST_SORT_LDA,
    ST_SORT_CMP,
    ST_SORT_WRA,
    ST_SRCH_RD,
    ST_SRCH_CMP
  } state_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

/* rtl/sorted_table_binary_search.sv */
// Top level of the sorted table search: sequencer, key table and comparator.
// Depends on stbs_pkg, stbs_mem, stbs_cmp.
//
// channel   direction  handshake            payload
// in_       in         start && !busy       in_req_type, in_key
// out_      out        out_valid (1 cycle)  out_found, out_position
//
// The load that fills the table starts an exchange sort on the single table
// read port, in passes over start index a.
// A search runs probes of a read and then a compare, at most log2(N)+1 probes;
// the result strobes in the same cycle that busy falls.
// Synchronous active-low reset empties the table; results cannot be held off.
module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_CHARS  = KEY_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [KEY_W-1:0] in_key,
  output logic             out_valid,
  output logic             out_found,
  output logic [POS_W-1:0] out_position
);

  localparam int KW    = 8 * KEY_CHARS;
  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int PW    = (IDX_W + 1 > POS_W) ? IDX_W + 1 : POS_W;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               sorted_r, sorted_nxt;
  logic [IDX_W-1:0]   a_r, a_nxt;
  logic [IDX_W-1:0]   b_r, b_nxt;
  logic [IDX_W-1:0]   mid_r, mid_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hx_r, hx_nxt;   // exclusive upper bound of the range
  logic [KW-1:0]      op_r, op_nxt;   // running minimum while sorting, search key otherwise
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [KW-1:0]      mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [KW-1:0]      mem_rdata;
  cmp_res_t           cmp;

  logic               fills_table;
  logic               range_open;
  logic [CNT_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid_probe;
  logic [PW-1:0]      pos_ext;

  stbs_mem #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (KW),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stbs_cmp #(
    .WIDTH (KW)
  ) u_cmp (
    .a   (op_r),
    .b   (mem_rdata),
    .res (cmp)
  );

  assign fills_table = (fill_r == CNT_W'(TABLE_SIZE - 1));
  assign range_open  = sorted_r && (lo_r < hx_r);
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hx_r} - (CNT_W + 1)'(1);
  assign mid_probe   = mid_sum[IDX_W:1];
  assign pos_ext     = PW'(mid_r) + PW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_req_type) begin
            state_nxt = ST_SRCH_RD;
          end else if (fills_table) begin
            state_nxt = ST_SORT_RDA;
          end
        end
      end
      ST_SORT_RDA: state_nxt = ST_SORT_LDA;
      ST_SORT_LDA: state_nxt = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (b_r == IDX_W'(TABLE_SIZE - 1)) begin
          state_nxt = ST_SORT_WRA;
        end
      end
      ST_SORT_WRA: begin
        state_nxt = (a_r == IDX_W'(TABLE_SIZE - 2)) ? ST_IDLE : ST_SORT_RDA;
      end
      ST_SRCH_RD:  state_nxt = range_open ? ST_SRCH_CMP : ST_IDLE;
      ST_SRCH_CMP: state_nxt = cmp.eq ? ST_IDLE : ST_SRCH_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    fill_nxt      = fill_r;
    sorted_nxt    = sorted_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    mid_nxt       = mid_r;
    lo_nxt        = lo_r;
    hx_nxt        = hx_r;
    op_nxt        = op_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = op_r;
    mem_raddr     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!in_req_type) begin
            mem_we    = 1'b1;
            mem_wdata = in_key[KW-1:0];
            a_nxt     = '0;
            if (fill_r == CNT_W'(TABLE_SIZE)) begin
              // full table: this key opens a new one
              mem_waddr  = '0;
              fill_nxt   = CNT_W'(1);
              sorted_nxt = 1'b0;
            end else begin
              mem_waddr = fill_r[IDX_W-1:0];
              fill_nxt  = fill_r + CNT_W'(1);
            end
          end else begin
            op_nxt = in_key[KW-1:0];
            lo_nxt = '0;
            hx_nxt = CNT_W'(TABLE_SIZE);
          end
        end
      end
      ST_SORT_RDA: begin
        mem_raddr = a_r;
      end
      ST_SORT_LDA: begin
        op_nxt    = mem_rdata;
        mem_raddr = a_r + IDX_W'(1);
        b_nxt     = a_r + IDX_W'(1);
      end
      ST_SORT_CMP: begin
        if (!cmp.lt && !cmp.eq) begin
          // held entry is larger: park it at b, keep the smaller one
          mem_we    = 1'b1;
          mem_waddr = b_r;
          op_nxt    = mem_rdata;
        end
        mem_raddr = b_r + IDX_W'(1);
        b_nxt     = b_r + IDX_W'(1);
      end
      ST_SORT_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = a_r;
        a_nxt     = a_r + IDX_W'(1);
        if (a_r == IDX_W'(TABLE_SIZE - 2)) begin
          sorted_nxt = 1'b1;
        end
      end
      ST_SRCH_RD: begin
        mem_raddr = mid_probe;
        mid_nxt   = mid_probe;
        if (!range_open) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_pos_nxt   = '0;
        end
      end
      ST_SRCH_CMP: begin
        priority if (cmp.eq) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = pos_ext[POS_W-1:0];
        end else if (cmp.lt) begin
          hx_nxt = CNT_W'(mid_r);
        end else begin
          lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      sorted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sorted_r    <= sorted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    mid_r       <= mid_nxt;
    lo_r        <= lo_nxt;
    hx_r        <= hx_nxt;
    op_r        <= op_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

/* rtl/stbs_mem.sv */
// Key table storage: one write port, one read port with registered data.
// Depends on nothing.
module stbs_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/stbs_cmp.sv */
// Shared key comparator, used by both the sort passes and the search probes.
// Depends on stbs_pkg.
module stbs_cmp
  import stbs_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output cmp_res_t         res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

/* rtl/stbs_chk.sv */
// Port-level checker for the sorted table search, bound to the top level.
// Depends on stbs_pkg and sorted_table_binary_search_defines.svh.
`include "sorted_table_binary_search_defines.svh"

module stbs_chk
  import stbs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             in_req_type,
  input logic             out_valid,
  input logic             out_found,
  input logic [POS_W-1:0] out_position
);

  `STBS_ASSERT_RST(a_reset_quiet, !rst_n |=> (!out_valid && !busy), "reset left block active")
  `STBS_ASSERT(a_search_busy, (start && !busy && in_req_type) |=> busy, "search not taken")
  `STBS_ASSERT(a_load_no_result, (start && !busy && !in_req_type) |=> !out_valid, "load made a result")
  `STBS_ASSERT(a_result_after_busy, out_valid |-> ($past(busy) && !busy), "stray result")
  `STBS_ASSERT(a_miss_pos_zero, (out_valid && !out_found) |-> (out_position == '0), "miss with position")

endmodule

bind sorted_table_binary_search stbs_chk u_stbs_chk (.*);
